@@ sv/dad_pkg.sv @@
// ----------------------------------------------------------------------------
// dad_pkg - shared types and constants for the date add/subtract pipeline
// Beat formats, calendar tables and fixed-point reciprocals for the
// constant dividers.
// ----------------------------------------------------------------------------
package dad_pkg;

  // Fixed calendar limits
  localparam int unsigned DN_W        = 22;        // day number 0..3652058
  localparam int unsigned MAX_DAYNUM  = 3652058;   // 9999-12-31
  localparam int unsigned MAX_YEAR    = 9999;
  localparam int unsigned DAYS_400Y   = 146097;
  localparam int unsigned DAYS_100Y   = 36524;
  localparam int unsigned DAYS_4Y     = 1461;
  localparam int unsigned DAYS_1Y     = 365;

  // Reciprocals, rounded up so the estimate is never low (corrected by one)
  localparam int unsigned RECIP_100   = 5243;      // >> 19, exact below 43699
  localparam int unsigned RECIP_400Y  = 3675;      // >> 29
  localparam int unsigned RECIP_4Y    = 11484;     // >> 24

  // Cycles from an accepted input beat to its result strobe
  localparam int unsigned LATENCY     = 10;

  typedef enum logic {
    FUNC_ADD = 1'b0,
    FUNC_SUB = 1'b1
  } func_t;

  typedef struct packed {
    logic        func;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [19:0] day_count;
  } in_item_t;

  typedef struct packed {
    logic [13:0] result_year;
    logic [3:0]  result_month;
    logic [4:0]  result_day;
    logic        range_error;
  } out_item_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  // Travels alongside every beat: start date and error flag
  typedef struct packed {
    date_t orig;
    logic  err;
  } carry_t;

  // Year split handed from the year stages to the month/day stage
  typedef struct packed {
    logic [13:0] year;
    logic [8:0]  yday;   // 0..365
    logic        leap;
  } ysplit_t;

  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] db;
    unique case (m)
      4'd2:    db = 9'd31;
      4'd3:    db = 9'd59;
      4'd4:    db = 9'd90;
      4'd5:    db = 9'd120;
      4'd6:    db = 9'd151;
      4'd7:    db = 9'd181;
      4'd8:    db = 9'd212;
      4'd9:    db = 9'd243;
      4'd10:   db = 9'd273;
      4'd11:   db = 9'd304;
      4'd12:   db = 9'd334;
      default: db = 9'd0;
    endcase
    return db;
  endfunction

  // First day of month m within its year, leap day included
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    return days_before(m) + ((leap && (m > 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

@@ sv/dad_to_daynum.sv @@
// ----------------------------------------------------------------------------
// dad_to_daynum - date to day number, then add or subtract the count
// Three stages: quotients, day number with validity check, offset and
// range check.
// ----------------------------------------------------------------------------
module dad_to_daynum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  dad_pkg::in_item_t             in_item,
  output logic                          dn_valid,
  output logic [dad_pkg::DN_W-1:0]      dn,
  output dad_pkg::carry_t               dn_carry
);

  // Stage 1: y-1, (y-1)/100, y/100, 365*(y-1)
  logic                         v1_r;
  dad_pkg::in_item_t            item1_r;
  logic [7:0]                   p100_r, y100_r;
  logic [dad_pkg::DN_W-1:0]     p365_r;
  logic [13:0]                  p1;
  logic [26:0]                  p_mul, y_mul;

  always_comb begin
    p1    = in_item.year - 14'd1;
    p_mul = 27'(p1) * 27'(dad_pkg::RECIP_100);
    y_mul = 27'(in_item.year) * 27'(dad_pkg::RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    item1_r <= in_item;
    p100_r  <= p_mul[26:19];
    y100_r  <= y_mul[26:19];
    p365_r  <= dad_pkg::DN_W'(p1) * dad_pkg::DN_W'(dad_pkg::DAYS_1Y);
  end

  // Stage 2: leap flag, date check, day number since 0001-01-01
  logic                         v2_r;
  dad_pkg::in_item_t            item2_r;
  logic                         err2_r;
  logic [dad_pkg::DN_W-1:0]     dn2_r;
  logic [13:0]                  p2;
  logic [14:0]                  y100x;
  logic                         cent, leap2, ok2;
  logic [4:0]                   dim;
  logic [dad_pkg::DN_W-1:0]     dn2_nxt;

  always_comb begin
    p2     = item1_r.year - 14'd1;
    y100x  = 15'(y100_r) * 15'd100;
    cent   = ({1'b0, item1_r.year} == y100x);
    leap2  = ((item1_r.year[1:0] == 2'b00) && !cent) || (cent && (y100_r[1:0] == 2'b00));
    dim    = dad_pkg::days_in_month(item1_r.month, leap2);
    ok2    = (item1_r.year >= 14'd1) && (item1_r.year <= 14'(dad_pkg::MAX_YEAR)) &&
             (item1_r.month >= 4'd1) && (item1_r.month <= 4'd12) &&
             (item1_r.day >= 5'd1) && (item1_r.day <= dim);
    dn2_nxt = p365_r + dad_pkg::DN_W'(p2 >> 2) - dad_pkg::DN_W'(p100_r)
            + dad_pkg::DN_W'(p100_r >> 2)
            + dad_pkg::DN_W'(dad_pkg::month_start(item1_r.month, leap2))
            + dad_pkg::DN_W'(item1_r.day) - dad_pkg::DN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    item2_r <= item1_r;
    err2_r  <= !ok2;
    dn2_r   <= dn2_nxt;
  end

  // Stage 3: apply the count, flag results outside the calendar
  logic                         v3_r;
  dad_pkg::carry_t              carry3_r, carry3_nxt;
  logic [dad_pkg::DN_W-1:0]     dn3_r, dn3_nxt;
  logic [dad_pkg::DN_W:0]       sum3;

  always_comb begin
    sum3 = {1'b0, dn2_r} + (dad_pkg::DN_W + 1)'(item2_r.day_count);
    carry3_nxt.orig.year  = item2_r.year;
    carry3_nxt.orig.month = item2_r.month;
    carry3_nxt.orig.day   = item2_r.day;
    if (dad_pkg::func_t'(item2_r.func) == dad_pkg::FUNC_SUB) begin
      carry3_nxt.err = err2_r || (dad_pkg::DN_W'(item2_r.day_count) > dn2_r);
      dn3_nxt        = dn2_r - dad_pkg::DN_W'(item2_r.day_count);
    end else begin
      carry3_nxt.err = err2_r || (sum3 > (dad_pkg::DN_W + 1)'(dad_pkg::MAX_DAYNUM));
      dn3_nxt        = sum3[dad_pkg::DN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    carry3_r <= carry3_nxt;
    dn3_r    <= dn3_nxt;
  end

  assign dn_valid = v3_r;
  assign dn       = dn3_r;
  assign dn_carry = carry3_r;

endmodule

@@ sv/dad_split_years.sv @@
// ----------------------------------------------------------------------------
// dad_split_years - day number to year and day of year
// Six stages: 400-year cycle (estimate, correct), centuries, 4-year cycle
// (estimate, correct), single years with year assembly.
// ----------------------------------------------------------------------------
module dad_split_years (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          dn_valid,
  input  logic [dad_pkg::DN_W-1:0]      dn,
  input  dad_pkg::carry_t               dn_carry,
  output logic                          ys_valid,
  output dad_pkg::ysplit_t              ys,
  output dad_pkg::carry_t               ys_carry
);

  // Stage 4: q400 estimate, never low
  logic                         v4_r;
  dad_pkg::carry_t              c4_r;
  logic [dad_pkg::DN_W-1:0]     n4_r;
  logic [4:0]                   q400e_r;
  logic [33:0]                  m4;

  assign m4 = 34'(dn) * 34'(dad_pkg::RECIP_400Y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= dn_valid;
    end
    c4_r    <= dn_carry;
    n4_r    <= dn;
    q400e_r <= m4[33:29];
  end

  // Stage 5: remainder, step back once if the estimate was high
  logic                         v5_r;
  dad_pkg::carry_t              c5_r;
  logic [4:0]                   q400_r;
  logic [17:0]                  r400_r;
  logic [23:0]                  d5, r5;

  always_comb begin
    d5 = {2'b00, n4_r} - (24'(q400e_r) * 24'(dad_pkg::DAYS_400Y));
    r5 = d5[23] ? d5 + 24'(dad_pkg::DAYS_400Y) : d5;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    c5_r   <= c4_r;
    q400_r <= q400e_r - 5'(d5[23]);
    r400_r <= r5[17:0];
  end

  // Stage 6: centuries by compare, last day of a 400-year cycle stays in century 3
  logic                         v6_r;
  dad_pkg::carry_t              c6_r;
  logic [4:0]                   q400_6_r;
  logic [1:0]                   q100_r, q100_nxt;
  logic [15:0]                  r1_r;
  logic [17:0]                  off6;

  always_comb begin
    priority if (r400_r >= 18'(3 * dad_pkg::DAYS_100Y)) begin
      q100_nxt = 2'd3;
      off6     = 18'(3 * dad_pkg::DAYS_100Y);
    end else if (r400_r >= 18'(2 * dad_pkg::DAYS_100Y)) begin
      q100_nxt = 2'd2;
      off6     = 18'(2 * dad_pkg::DAYS_100Y);
    end else if (r400_r >= 18'(dad_pkg::DAYS_100Y)) begin
      q100_nxt = 2'd1;
      off6     = 18'(dad_pkg::DAYS_100Y);
    end else begin
      q100_nxt = 2'd0;
      off6     = 18'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    c6_r     <= c5_r;
    q400_6_r <= q400_r;
    q100_r   <= q100_nxt;
    r1_r     <= 16'(r400_r - off6);
  end

  // Stage 7: q4 estimate, never low
  logic                         v7_r;
  dad_pkg::carry_t              c7_r;
  logic [4:0]                   q400_7_r;
  logic [1:0]                   q100_7_r;
  logic [15:0]                  r1_7_r;
  logic [5:0]                   q4e_r;
  logic [29:0]                  m7;

  assign m7 = 30'(r1_r) * 30'(dad_pkg::RECIP_4Y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    c7_r     <= c6_r;
    q400_7_r <= q400_6_r;
    q100_7_r <= q100_r;
    r1_7_r   <= r1_r;
    q4e_r    <= m7[29:24];
  end

  // Stage 8: remainder within the 4-year cycle, corrected
  logic                         v8_r;
  dad_pkg::carry_t              c8_r;
  logic [4:0]                   q400_8_r;
  logic [1:0]                   q100_8_r;
  logic [4:0]                   q4_r;
  logic [10:0]                  r2_r;
  logic [16:0]                  d8, r8;

  always_comb begin
    d8 = {1'b0, r1_7_r} - (17'(q4e_r) * 17'(dad_pkg::DAYS_4Y));
    r8 = d8[16] ? d8 + 17'(dad_pkg::DAYS_4Y) : d8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
    c8_r     <= c7_r;
    q400_8_r <= q400_7_r;
    q100_8_r <= q100_7_r;
    q4_r     <= 5'(q4e_r - 6'(d8[16]));
    r2_r     <= r8[10:0];
  end

  // Stage 9: single years by compare, year assembly, leap flag
  logic                         v9_r;
  dad_pkg::carry_t              c9_r;
  dad_pkg::ysplit_t             ys9_r, ys9_nxt;
  logic [1:0]                   q1;
  logic [10:0]                  off9;

  always_comb begin
    priority if (r2_r >= 11'(3 * dad_pkg::DAYS_1Y)) begin
      q1   = 2'd3;
      off9 = 11'(3 * dad_pkg::DAYS_1Y);
    end else if (r2_r >= 11'(2 * dad_pkg::DAYS_1Y)) begin
      q1   = 2'd2;
      off9 = 11'(2 * dad_pkg::DAYS_1Y);
    end else if (r2_r >= 11'(dad_pkg::DAYS_1Y)) begin
      q1   = 2'd1;
      off9 = 11'(dad_pkg::DAYS_1Y);
    end else begin
      q1   = 2'd0;
      off9 = 11'd0;
    end
    ys9_nxt.yday = 9'(r2_r - off9);
    ys9_nxt.year = 14'(q400_8_r) * 14'd400 + 14'(q100_8_r) * 14'd100
                 + {7'd0, q4_r, 2'b00} + 14'(q1) + 14'd1;
    // last year of a 4-year block, unless it ends a non-400 century
    ys9_nxt.leap = (q1 == 2'd3) && ((q4_r != 5'd24) || (q100_8_r == 2'd3));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= v8_r;
    end
    c9_r  <= c8_r;
    ys9_r <= ys9_nxt;
  end

  assign ys_valid = v9_r;
  assign ys       = ys9_r;
  assign ys_carry = c9_r;

endmodule

@@ sv/dad_to_date.sv @@
// ----------------------------------------------------------------------------
// dad_to_date - day of year to month and day, output register
// Month found by parallel compares against month starts; error beats
// return the start date.
// ----------------------------------------------------------------------------
module dad_to_date (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ys_valid,
  input  dad_pkg::ysplit_t      ys,
  input  dad_pkg::carry_t       ys_carry,
  output logic                  out_valid,
  output dad_pkg::out_item_t    out_data
);

  logic                 v10_r;
  dad_pkg::out_item_t   out10_r, out10_nxt;
  logic [3:0]           mcnt, month;
  logic [8:0]           mstart;

  always_comb begin
    mcnt = 4'd0;
    for (int k = 2; k <= 12; k++) begin
      if (ys.yday >= dad_pkg::month_start(4'(k), ys.leap)) begin
        mcnt = mcnt + 4'd1;
      end
    end
    month  = mcnt + 4'd1;
    mstart = dad_pkg::month_start(month, ys.leap);
    if (ys_carry.err) begin
      out10_nxt.result_year  = ys_carry.orig.year;
      out10_nxt.result_month = ys_carry.orig.month;
      out10_nxt.result_day   = ys_carry.orig.day;
    end else begin
      out10_nxt.result_year  = ys.year;
      out10_nxt.result_month = month;
      out10_nxt.result_day   = 5'(ys.yday - mstart + 9'd1);
    end
    out10_nxt.range_error = ys_carry.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else begin
      v10_r <= ys_valid;
    end
    out10_r <= out10_nxt;
  end

  assign out_valid = v10_r;
  assign out_data  = out10_r;

endmodule

@@ sv/date_add_subtract_days.sv @@
// ----------------------------------------------------------------------------
// date_add_subtract_days - Gregorian date plus or minus a day count
// Exact calendar arithmetic through a day number counted from 0001-01-01.
// Results outside years 1..9999, or an invalid start date, raise
// range_error and return the start date.
// ----------------------------------------------------------------------------
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+-----------------------------------
//  input    | start, busy, in_data      | beat taken when start && !busy
//  result   | out_valid, out_data       | one-cycle strobe, no back-pressure
//
// One beat per cycle, fully pipelined: each beat's result strobes once it has
// passed the ten register stages (three to day number, six to year, one to
// month/day and output); the delay is dad_pkg::LATENCY.
// Reset (rst_n low, synchronous) clears all stage valid bits; busy is high
// only while reset is held. The receiver cannot stall, so nothing in the
// pipe ever waits and busy never rises in normal operation.
//
module date_add_subtract_days (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  dad_pkg::in_item_t     in_data,
  output logic                  out_valid,
  output dad_pkg::out_item_t    out_data
);

  logic                         accept;

  // date -> day number -> offset
  logic                         dn_valid;
  logic [dad_pkg::DN_W-1:0]     dn;
  dad_pkg::carry_t              dn_carry;

  // day number -> year / day of year
  logic                         ys_valid;
  dad_pkg::ysplit_t             ys;
  dad_pkg::carry_t              ys_carry;

  // Only reset holds off input; every stage advances every cycle.
  assign busy   = !rst_n;
  assign accept = start && !busy;

  dad_to_daynum u_to_daynum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_item  (in_data),
    .dn_valid (dn_valid),
    .dn       (dn),
    .dn_carry (dn_carry)
  );

  dad_split_years u_split_years (
    .clk      (clk),
    .rst_n    (rst_n),
    .dn_valid (dn_valid),
    .dn       (dn),
    .dn_carry (dn_carry),
    .ys_valid (ys_valid),
    .ys       (ys),
    .ys_carry (ys_carry)
  );

  // Output register lives in the last stage.
  dad_to_date u_to_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .ys_valid  (ys_valid),
    .ys        (ys),
    .ys_carry  (ys_carry),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ sv/dad_checker.sv @@
// ----------------------------------------------------------------------------
// dad_checker - port-level checks for date_add_subtract_days
// Fixed latency, no invented results, sane dates, error returns the start.
// ----------------------------------------------------------------------------
module dad_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input dad_pkg::in_item_t    in_data,
  input logic                 out_valid,
  input dad_pkg::out_item_t   out_data
);

  localparam int unsigned LAT = dad_pkg::LATENCY;

  // Every taken beat strobes a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after accepted beat");

  // No strobe without a matching beat taken earlier
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LAT !out_valid)
    else $error("result strobe without accepted beat");

  // A good result has year 1..9999, month 1..12 and day 1..31
  a_good_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.range_error) |->
      (out_data.result_year >= 14'd1) && (out_data.result_year <= 14'd9999) &&
      (out_data.result_month >= 4'd1) && (out_data.result_month <= 4'd12) &&
      (out_data.result_day >= 5'd1) && (out_data.result_day <= 5'd31))
    else $error("result date out of range");

  // An error result returns the start date of its beat
  a_err_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.range_error) |->
      (out_data.result_year == $past(in_data.year, LAT)) &&
      (out_data.result_month == $past(in_data.month, LAT)) &&
      (out_data.result_day == $past(in_data.day, LAT)))
    else $error("error result does not return start date");

endmodule

bind date_add_subtract_days dad_checker u_dad_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - date_add_subtract_days checker
// Drives dated requests through the command port with random gaps and checks
// every result strobe against an in-bench calendar predictor: directed
// corner cases first, then randomized traffic weighted toward leap days,
// range limits and invalid dates.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RANDOM_BEATS = 650;
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no beat taken either way
  localparam int unsigned REPORT_MAX   = 10;

  // One request waiting for its result, kept with its prediction
  typedef struct {
    dad_pkg::in_item_t  req;
    dad_pkg::out_item_t want;
  } date_job_t;

  // --------------------------------------------------------------------------
  // Scoreboard: calendar predictor plus in-order store of predicted dates
  // --------------------------------------------------------------------------
  class date_scoreboard;
    date_job_t   open_jobs[$];
    int unsigned failures;

    static function bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    // 0 for a month code outside 1..12, so any day fails the range test
    static function int unsigned month_length(int unsigned y, int unsigned m);
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return leap_year(y) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    // Days since 0001-01-01
    static function int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
      int unsigned p;
      int unsigned n;
      p = y - 1;
      n = 365 * p + p / 4 - p / 100 + p / 400;
      for (int unsigned k = 1; k < m; k++) n += month_length(y, k);
      return n + d - 1;
    endfunction

    static function void date_of(input int unsigned dn, output int unsigned y,
                                 output int unsigned m, output int unsigned d);
      int unsigned rem;
      int unsigned c100;
      int unsigned c1;
      y   = (dn / dad_pkg::DAYS_400Y) * 400;
      rem = dn % dad_pkg::DAYS_400Y;
      // last century / last year of a cycle is one day longer: clamp
      c100 = rem / dad_pkg::DAYS_100Y;
      if (c100 > 3) c100 = 3;
      rem -= c100 * dad_pkg::DAYS_100Y;
      y   += c100 * 100 + (rem / dad_pkg::DAYS_4Y) * 4;
      rem  = rem % dad_pkg::DAYS_4Y;
      c1   = rem / dad_pkg::DAYS_1Y;
      if (c1 > 3) c1 = 3;
      rem -= c1 * dad_pkg::DAYS_1Y;
      y   += c1 + 1;
      m = 1;
      while (m < 12 && rem >= month_length(y, m)) begin
        rem -= month_length(y, m);
        m++;
      end
      d = rem + 1;
    endfunction

    function dad_pkg::out_item_t shifted_date(dad_pkg::in_item_t req);
      dad_pkg::out_item_t res;
      int unsigned        y, m, d, n;
      y = req.year;
      m = req.month;
      d = req.day;
      // bad start date or out-of-range result: echo the start fields
      res.result_year  = req.year;
      res.result_month = req.month;
      res.result_day   = req.day;
      res.range_error  = 1'b0;
      if (y < 1 || y > dad_pkg::MAX_YEAR || m < 1 || m > 12 || d < 1 ||
          d > month_length(y, m)) begin
        res.range_error = 1'b1;
      end else begin
        n = day_number(y, m, d);
        if (req.func == dad_pkg::FUNC_ADD) begin
          if (n + req.day_count > dad_pkg::MAX_DAYNUM) res.range_error = 1'b1;
          else n += req.day_count;
        end else begin
          if (req.day_count > n) res.range_error = 1'b1;
          else n -= req.day_count;
        end
        if (!res.range_error) begin
          date_of(n, y, m, d);
          res.result_year  = y[13:0];
          res.result_month = m[3:0];
          res.result_day   = d[4:0];
        end
      end
      return res;
    endfunction

    function void note_request(dad_pkg::in_item_t req);
      date_job_t job;
      job.req  = req;
      job.want = shifted_date(req);
      open_jobs.push_back(job);
    endfunction

    function void check_result(dad_pkg::out_item_t got);
      date_job_t job;
      if (open_jobs.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("unexpected result beat: %0d-%0d-%0d err=%0b",
                   got.result_year, got.result_month, got.result_day, got.range_error);
        return;
      end
      job = open_jobs.pop_front();
      if (got.result_year !== job.want.result_year ||
          got.result_month !== job.want.result_month ||
          got.result_day !== job.want.result_day ||
          got.range_error !== job.want.range_error) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display({"mismatch: %0d-%0d-%0d %s %0d days: ",
                    "want %0d-%0d-%0d err=%0b, got %0d-%0d-%0d err=%0b"},
                   job.req.year, job.req.month, job.req.day, job.req.func ? "-" : "+",
                   job.req.day_count, job.want.result_year, job.want.result_month,
                   job.want.result_day, job.want.range_error, got.result_year,
                   got.result_month, got.result_day, got.range_error);
      end
    endfunction

    function int unsigned outstanding();
      return open_jobs.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and clock/reset
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  dad_pkg::in_item_t  in_data;
  logic               out_valid;
  dad_pkg::out_item_t out_data;

  date_add_subtract_days u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  date_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: both channels sampled at the edge that takes the beat.
  // Values read here are the pre-edge ones, so DUT and bench NBAs can't race.
  // --------------------------------------------------------------------------
  int unsigned idle_cycles;

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_data);
      if (out_valid) sb.check_result(out_data);
    end
  end

  // Watchdog: a hung handshake or lost strobe ends the run
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic dad_pkg::in_item_t date_request(dad_pkg::func_t f, int unsigned y,
                                                     int unsigned m, int unsigned d,
                                                     int unsigned cnt);
    dad_pkg::in_item_t r;
    r.func      = f;
    r.year      = y[13:0];
    r.month     = m[3:0];
    r.day       = d[4:0];
    r.day_count = cnt[19:0];
    return r;
  endfunction

  function automatic dad_pkg::func_t rand_func();
    return ($urandom_range(0, 1) != 0) ? dad_pkg::FUNC_SUB : dad_pkg::FUNC_ADD;
  endfunction

  // Mostly short counts so results land in nearby months; some full-width
  function automatic int unsigned rand_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 31);
    if (r < 60) return $urandom_range(0, 4095);
    if (r < 85) return $urandom_range(0, 131071);
    return $urandom_range(0, 1048575);
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void random_date(output int unsigned y, output int unsigned m,
                                      output int unsigned d);
    y = $urandom_range(1, dad_pkg::MAX_YEAR);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, date_scoreboard::month_length(y, m));
  endfunction

  // Hold start until the beat is taken, then optionally idle.
  // On a zero gap start stays high, so only one NBA hits it per step.
  task automatic issue(dad_pkg::in_item_t req, bit no_gap);
    int unsigned gap;
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy !== 1'b0);
    gap = no_gap ? 0 : rand_gap();
    if (gap != 0) begin
      start   <= 1'b0;
      in_data <= dad_pkg::in_item_t'({$urandom, $urandom});  // junk while idle
      repeat (gap) @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned       y, m, d, cnt, dn, r;
    dad_pkg::in_item_t req;

    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero counts, range limits both ways, leap-day arithmetic,
    // century rules, and invalid start dates (echoed with range_error)
    issue(date_request(dad_pkg::FUNC_ADD, 2024, 2, 29, 0), 0);
    issue(date_request(dad_pkg::FUNC_SUB, 1, 1, 1, 0), 0);
    issue(date_request(dad_pkg::FUNC_ADD, 9999, 12, 31, 1), 0);
    issue(date_request(dad_pkg::FUNC_SUB, 1, 1, 1, 1), 0);
    issue(date_request(dad_pkg::FUNC_ADD, 1, 1, 1, 1048575), 1);
    issue(date_request(dad_pkg::FUNC_SUB, 9999, 12, 31, 1048575), 1);
    issue(date_request(dad_pkg::FUNC_SUB, 1, 1, 1, 1048575), 1);
    issue(date_request(dad_pkg::FUNC_ADD, 9999, 12, 31, 1048575), 0);
    issue(date_request(dad_pkg::FUNC_ADD, 2000, 2, 29, 365), 0);
    issue(date_request(dad_pkg::FUNC_SUB, 2004, 2, 29, 1461), 0);
    issue(date_request(dad_pkg::FUNC_ADD, 1900, 2, 28, 1), 1);
    issue(date_request(dad_pkg::FUNC_ADD, 2000, 2, 28, 1), 1);
    issue(date_request(dad_pkg::FUNC_ADD, 1999, 12, 31, 1), 0);
    issue(date_request(dad_pkg::FUNC_SUB, 2100, 3, 1, 1), 0);
    issue(date_request(dad_pkg::FUNC_ADD, 1600, 2, 29, 146097), 0);
    issue(date_request(dad_pkg::FUNC_ADD, 0, 6, 15, 10), 0);
    issue(date_request(dad_pkg::FUNC_SUB, 16383, 15, 31, 1048575), 0);  // every input bit set
    issue(date_request(dad_pkg::FUNC_ADD, 0, 0, 0, 0), 1);              // every input bit clear
    issue(date_request(dad_pkg::FUNC_ADD, 2020, 13, 1, 5), 0);
    issue(date_request(dad_pkg::FUNC_SUB, 2023, 5, 0, 5), 0);
    issue(date_request(dad_pkg::FUNC_ADD, 1900, 2, 29, 1), 0);
    issue(date_request(dad_pkg::FUNC_SUB, 2024, 2, 30, 1), 0);
    issue(date_request(dad_pkg::FUNC_ADD, 2023, 4, 31, 1), 0);
    issue(date_request(dad_pkg::FUNC_ADD, 10000, 1, 1, 0), 0);

    // Random traffic; the first 30 beats of every 120 run with no gaps
    for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        random_date(y, m, d);
        req = date_request(rand_func(), y, m, d, rand_count());
      end else if (r < 70) begin
        // leap-rule years and month/year boundaries
        case ($urandom_range(0, 3))
          0:       y = 400 * $urandom_range(1, 24);
          1:       y = 100 * $urandom_range(1, 99);
          2:       y = 4 * $urandom_range(1, 2499);
          default: y = $urandom_range(1, dad_pkg::MAX_YEAR);
        endcase
        case ($urandom_range(0, 4))
          0:       begin m = 2;  d = 28; end
          1:       begin m = 2;  d = date_scoreboard::leap_year(y) ? 29 : 28; end
          2:       begin m = 3;  d = 1;  end
          3:       begin m = 12; d = 31; end
          default: begin m = 1;  d = 1;  end
        endcase
        req = date_request(rand_func(), y, m, d, $urandom_range(0, 2000));
      end else if (r < 85) begin
        // result lands exactly on, or one day past, a range limit
        cnt = $urandom_range(1, 1048575);
        if ($urandom_range(0, 1) != 0) begin
          dn = dad_pkg::MAX_DAYNUM - cnt + $urandom_range(0, 1);
          date_scoreboard::date_of(dn, y, m, d);
          req = date_request(dad_pkg::FUNC_ADD, y, m, d, cnt);
        end else begin
          dn = cnt - $urandom_range(0, 1);
          date_scoreboard::date_of(dn, y, m, d);
          req = date_request(dad_pkg::FUNC_SUB, y, m, d, cnt);
        end
      end else if (r < 93) begin
        // one field broken, the rest plausible
        random_date(y, m, d);
        case ($urandom_range(0, 4))
          0: y = 0;
          1: y = $urandom_range(dad_pkg::MAX_YEAR + 1, 16383);
          2: m = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(13, 15);
          3: d = 0;
          default: begin
            case ($urandom_range(0, 4))
              0:       m = 2;
              1:       m = 4;
              2:       m = 6;
              3:       m = 9;
              default: m = 11;
            endcase
            d = $urandom_range(date_scoreboard::month_length(y, m) + 1, 31);
          end
        endcase
        req = date_request(rand_func(), y, m, d, rand_count());
      end else begin
        req = dad_pkg::in_item_t'({$urandom, $urandom});
      end
      issue(req, (i % 120) < 30);
    end
    start <= 1'b0;

    // Drain: every prediction matched, then quiet so any stray strobe is caught
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (dad_pkg::LATENCY + 4) @(posedge clk);

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
